FILE: rtl/fdx_pkg.sv
// Shared constants for the float frexp decomposition block.
`default_nettype none

package fdx_pkg;

    localparam int unsigned MAN_W     = 52;
    localparam int unsigned SGL_MAN_W = 23;
    localparam int unsigned EXP_W     = 11;
    localparam int unsigned SH_W      = 6;
    localparam int unsigned EXP_OUT_W = 12;
    localparam int unsigned EXP_CALC_W = 13;

    localparam logic [0:0] CMD_SINGLE = 1'b0;
    localparam logic [0:0] CMD_DOUBLE = 1'b1;

    localparam logic [7:0]  SGL_EXP_MAX  = 8'hff;
    localparam logic [10:0] DBL_EXP_MAX  = 11'h7ff;
    localparam logic [7:0]  SGL_HALF_EXP = 8'h7e;
    localparam logic [10:0] DBL_HALF_EXP = 11'h3fe;

    localparam logic [EXP_CALC_W-1:0] SGL_BIAS = 13'd127;
    localparam logic [EXP_CALC_W-1:0] DBL_BIAS = 13'd1023;

endpackage

`default_nettype wire

FILE: rtl/float_frexp_decompose_top.sv
// Top level of the pipelined frexp decomposition for single and double patterns.
// The done strobe follows start through vld1_reg, vld2_reg and done_reg in that order.
// Throughput: one item per cycle; busy is held low, the pipeline never stalls.
// Stages: classify and align, leading-zero count, normalize shift and assembly.
// Reset clears the valid bits only; payload registers are not reset.
// The receiver cannot stall, so no result is ever held back.
`default_nettype none

module float_frexp_decompose_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [0:0]  command,
    input  wire logic [63:0] value_bits,
    output logic             done,
    output logic [63:0]      fraction_bits,
    output logic signed [11:0] binary_exponent
);
    import fdx_pkg::*;

    logic                  vld1_reg;
    logic                  dbl1_reg;
    logic [63:0]           val1_reg;
    logic                  spec1_reg;
    logic [EXP_W-1:0]      expf1_reg;
    logic [MAN_W-1:0]      man1_reg;

    logic                  vld2_reg;
    logic                  dbl2_reg;
    logic [63:0]           val2_reg;
    logic                  spec2_reg;
    logic [EXP_W-1:0]      expf2_reg;
    logic [MAN_W-1:0]      man2_reg;
    logic [SH_W-1:0]       lz2_reg;

    logic                  done_reg;
    logic [63:0]           frac_reg;
    logic [EXP_OUT_W-1:0]  exp_reg;

    logic                  dbl1_next;
    logic [63:0]           val1_next;
    logic                  spec1_next;
    logic [EXP_W-1:0]      expf1_next;
    logic [MAN_W-1:0]      man1_next;
    logic [SH_W-1:0]       lz2_next;
    logic [63:0]           frac_next;
    logic [EXP_OUT_W-1:0]  exp_next;

    logic [63:0]           lz_word;
    logic [SH_W-1:0]       sh_amt;
    logic [MAN_W-1:0]      man_shift;
    logic [MAN_W-1:0]      man_norm;
    logic [EXP_CALC_W-1:0] bias;
    logic [EXP_CALC_W-1:0] exp_calc;

    assign busy = 1'b0;

    // Stage 1: classify and align
    always_comb
    begin
        dbl1_next = (command == CMD_DOUBLE);
        if (dbl1_next)
        begin
            val1_next  = value_bits;
            expf1_next = value_bits[62:52];
            man1_next  = value_bits[51:0];
            spec1_next = (value_bits[62:52] == DBL_EXP_MAX) || (value_bits[62:0] == 63'd0);
        end
        else
        begin
            val1_next  = {32'd0, value_bits[31:0]};
            expf1_next = {3'd0, value_bits[30:23]};
            man1_next  = {value_bits[22:0], {(MAN_W-SGL_MAN_W){1'b0}}};
            spec1_next = (value_bits[30:23] == SGL_EXP_MAX) || (value_bits[30:0] == 31'd0);
        end
    end

    // Stage 2: leading-zero count by halving
    always_comb
    begin
        lz_word  = {man1_reg, 12'd0};
        lz2_next = '0;
        if (lz_word[63:32] == 32'd0)
        begin
            lz2_next[5] = 1'b1;
            lz_word     = lz_word << 32;
        end
        if (lz_word[63:48] == 16'd0)
        begin
            lz2_next[4] = 1'b1;
            lz_word     = lz_word << 16;
        end
        if (lz_word[63:56] == 8'd0)
        begin
            lz2_next[3] = 1'b1;
            lz_word     = lz_word << 8;
        end
        if (lz_word[63:60] == 4'd0)
        begin
            lz2_next[2] = 1'b1;
            lz_word     = lz_word << 4;
        end
        if (lz_word[63:62] == 2'd0)
        begin
            lz2_next[1] = 1'b1;
            lz_word     = lz_word << 2;
        end
        if (lz_word[63] == 1'b0)
        begin
            lz2_next[0] = 1'b1;
        end
    end

    // Stage 3: normalize and assemble
    always_comb
    begin
        sh_amt    = lz2_reg + 6'd1;
        man_shift = man2_reg << sh_amt;
        bias      = dbl2_reg ? DBL_BIAS : SGL_BIAS;
        if (expf2_reg == '0)
        begin
            man_norm = man_shift;
            exp_calc = 13'd1 - bias - {7'd0, lz2_reg};
        end
        else
        begin
            man_norm = man2_reg;
            exp_calc = {2'd0, expf2_reg} - bias + 13'd1;
        end
        if (spec2_reg)
        begin
            frac_next = val2_reg;
            exp_next  = '0;
        end
        else
        begin
            if (dbl2_reg)
            begin
                frac_next = {val2_reg[63], DBL_HALF_EXP, man_norm};
            end
            else
            begin
                frac_next = {32'd0, val2_reg[31], SGL_HALF_EXP,
                             man_norm[MAN_W-1 -: SGL_MAN_W]};
            end
            exp_next = exp_calc[EXP_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start && !busy;
            vld2_reg <= vld1_reg;
            done_reg <= vld2_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        dbl1_reg  <= dbl1_next;
        val1_reg  <= val1_next;
        spec1_reg <= spec1_next;
        expf1_reg <= expf1_next;
        man1_reg  <= man1_next;

        dbl2_reg  <= dbl1_reg;
        val2_reg  <= val1_reg;
        spec2_reg <= spec1_reg;
        expf2_reg <= expf1_reg;
        man2_reg  <= man1_reg;
        lz2_reg   <= lz2_next;

        frac_reg  <= frac_next;
        exp_reg   <= exp_next;
    end

    assign done            = done_reg;
    assign fraction_bits   = frac_reg;
    assign binary_exponent = $signed(exp_reg);

endmodule

`default_nettype wire
